@@ rtl/core/bfiq_pkg.sv @@
// ----------------------------------------------------------------------------
// Bloom filter package
// Shared constants, types and controller state encoding.
// ----------------------------------------------------------------------------
`default_nettype none

package bfiq_pkg;

    localparam int FILTER_BITS_DEF = 1024;
    localparam int NH_W            = 6;
    localparam int FS_W            = 11;
    localparam int KEY_W           = 64;
    localparam int CFG_IDX_W       = 1;
    localparam int CFG_DATA_W      = 11;

    localparam logic [CFG_IDX_W-1:0] REG_NUM_HASHES  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FILTER_SIZE = 1'd1;

    localparam logic [NH_W-1:0] NUM_HASHES_RST  = 6'd10;
    localparam logic [FS_W-1:0] FILTER_SIZE_RST = 11'd64;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    localparam logic [63:0] MM_C1 = 64'h87c37b91114253d5;
    localparam logic [63:0] MM_C2 = 64'h4cf5ad432745937f;
    localparam logic [63:0] FM_C1 = 64'hff51afd7ed558ccd;
    localparam logic [63:0] FM_C2 = 64'hc4ceb9fe1a85ec53;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_MOD,
        ST_PROBE,
        ST_WAIT,
        ST_CHECK,
        ST_DONE
    } t_state;

    // Controller commands to the datapath.
    typedef struct packed {
        logic load;       // capture key and opcode
        logic hash_step;  // advance the hash sequencer
        logic mod_start;  // start the modulo unit on the current probe value
        logic mod_step;   // one restoring step
        logic mem_access; // read or write the probed entry
        logic next_probe; // advance to the next probe
        logic clr_step;   // clearing pass write
        logic done;       // present result
    } t_cmd;

    // Datapath status to the controller.
    typedef struct packed {
        logic hash_done;
        logic mod_done;
        logic probes_done;
        logic bit_zero;   // query saw a clear bit
        logic clr_done;
    } t_sts;

endpackage

`default_nettype wire

@@ rtl/core/bloom_filter_insert_query.sv @@
// Each key is hashed, then each probe value is reduced in the serial modulo unit,
// one bit a cycle over 64 bits, and its store entry is accessed; the result strobe
// follows the last probe, sooner when a query meets a clear bit.
// One key at a time: busy stays high from acceptance until the result strobe.
// Reset sweeps the bit store to zero, one entry a cycle, busy high.
// The receiver cannot stall; each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
// Bloom filter insert/query
// Top level: configuration registers, controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module bloom_filter_insert_query #(
    parameter int FILTER_BITS = bfiq_pkg::FILTER_BITS_DEF
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 start,
    output logic                                busy,
    input  wire                                 i_opcode,
    input  wire [bfiq_pkg::KEY_W-1:0]           i_key,
    output logic                                o_valid,
    output logic                                o_maybe_present,
    input  wire                                 i_cfg_we,
    input  wire [bfiq_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  wire [bfiq_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    logic [bfiq_pkg::NH_W-1:0] r_num_hashes;
    logic [bfiq_pkg::FS_W-1:0] r_filter_size;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_hashes  <= bfiq_pkg::NUM_HASHES_RST;
            r_filter_size <= bfiq_pkg::FILTER_SIZE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bfiq_pkg::REG_NUM_HASHES:  r_num_hashes  <= i_cfg_data[bfiq_pkg::NH_W-1:0];
                bfiq_pkg::REG_FILTER_SIZE: r_filter_size <= i_cfg_data;
                default: ;
            endcase
        end
    end

    bfiq_pkg::t_cmd cmd;
    bfiq_pkg::t_sts sts;

    bfiq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_busy  (busy),
        .o_cmd   (cmd)
    );

    bfiq_dp #(.FILTER_BITS(FILTER_BITS)) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_opcode        (i_opcode),
        .i_key           (i_key),
        .i_num_hashes    (r_num_hashes),
        .i_filter_size   (r_filter_size),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .o_valid         (o_valid),
        .o_maybe_present (o_maybe_present)
    );

    // A result word follows only a completed item.
    a_valid_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.done |=> o_valid) else $error("result strobe missing");
    // Strobe lasts one cycle.
    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("result strobe held");
    // Only one command of the store at a time.
    a_store_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.clr_step && cmd.mem_access)) else $error("store conflict");

endmodule

`default_nettype wire

@@ rtl/core/bfiq_ctrl.sv @@
// ----------------------------------------------------------------------------
// Bloom filter controller
// Sequences clearing, hashing, modulo reduction and per-probe store access.
// ----------------------------------------------------------------------------
`default_nettype none

module bfiq_ctrl (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_start,
    input  wire bfiq_pkg::t_sts   i_sts,
    output logic                  o_busy,
    output bfiq_pkg::t_cmd        o_cmd
);

    bfiq_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bfiq_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            bfiq_pkg::ST_CLEAR: if (i_sts.clr_done) n_state = bfiq_pkg::ST_IDLE;
            bfiq_pkg::ST_IDLE:  if (i_start) n_state = bfiq_pkg::ST_HASH;
            bfiq_pkg::ST_HASH:  if (i_sts.hash_done) n_state = bfiq_pkg::ST_CHECK;
            bfiq_pkg::ST_CHECK: begin
                if (i_sts.probes_done) n_state = bfiq_pkg::ST_DONE;
                else n_state = bfiq_pkg::ST_MOD;
            end
            bfiq_pkg::ST_MOD:   if (i_sts.mod_done) n_state = bfiq_pkg::ST_PROBE;
            bfiq_pkg::ST_PROBE: n_state = bfiq_pkg::ST_WAIT;
            bfiq_pkg::ST_WAIT: begin
                if (i_sts.bit_zero) n_state = bfiq_pkg::ST_DONE;
                else n_state = bfiq_pkg::ST_CHECK;
            end
            bfiq_pkg::ST_DONE:  n_state = bfiq_pkg::ST_IDLE;
            default:            n_state = bfiq_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        o_busy = 1'b1;
        case (r_state)
            bfiq_pkg::ST_CLEAR: o_cmd.clr_step = 1'b1;
            bfiq_pkg::ST_IDLE: begin
                o_busy = 1'b0;
                o_cmd.load = i_start;
            end
            bfiq_pkg::ST_HASH:  o_cmd.hash_step = 1'b1;
            bfiq_pkg::ST_CHECK: o_cmd.mod_start = !i_sts.probes_done;
            bfiq_pkg::ST_MOD:   o_cmd.mod_step = 1'b1;
            bfiq_pkg::ST_PROBE: o_cmd.mem_access = 1'b1;
            bfiq_pkg::ST_WAIT:  o_cmd.next_probe = 1'b1;
            bfiq_pkg::ST_DONE:  o_cmd.done = 1'b1;
            default:            o_busy = 1'b1;
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/core/bfiq_dp.sv @@
// ----------------------------------------------------------------------------
// Bloom filter datapath
// Multi-cycle MurmurHash3 sequencer, serial modulo unit and the bit store.
// ----------------------------------------------------------------------------
`default_nettype none

module bfiq_dp #(
    parameter int FILTER_BITS = bfiq_pkg::FILTER_BITS_DEF
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_opcode,
    input  wire [bfiq_pkg::KEY_W-1:0]      i_key,
    input  wire [bfiq_pkg::NH_W-1:0]       i_num_hashes,
    input  wire [bfiq_pkg::FS_W-1:0]       i_filter_size,
    input  wire bfiq_pkg::t_cmd            i_cmd,
    output bfiq_pkg::t_sts                 o_sts,
    output logic                           o_valid,
    output logic                           o_maybe_present
);

    localparam int AW  = $clog2(FILTER_BITS);
    localparam int MW  = AW + 1;

    // ---------------- hash sequencer ----------------
    // 32-bit partial products: each 64x64 low product is summed from three of them.
    logic [63:0] r_h1, r_h2, r_acc, r_a, r_b;
    logic [4:0]  r_hstep, n_hstep;
    logic [1:0]  r_pp;
    logic        r_op;

    logic [63:0] pp;
    always_comb begin
        case (r_pp)
            2'd0:    pp = {32'd0, r_a[31:0]} * {32'd0, r_b[31:0]};
            2'd1:    pp = {r_a[31:0] * r_b[63:32], 32'd0};
            2'd2:    pp = {r_a[63:32] * r_b[31:0], 32'd0};
            default: pp = '0;
        endcase
    end

    // Steps: mul words accumulate pp 0..2, then take a settle step.
    // Sequence: k*C1, rot, *C2, combine, fmix(h1) x2 muls, fmix(h2) x2 muls, final.
    logic mul_last;
    assign mul_last = (r_pp == 2'd3);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_opcode;
            r_a     <= i_key;
            r_b     <= bfiq_pkg::MM_C1;
            r_acc   <= '0;
            r_pp    <= 2'd0;
            r_hstep <= 5'd0;
        end else if (i_cmd.hash_step) begin
            r_hstep <= n_hstep;
            if (r_hstep == 5'd0 || r_hstep == 5'd2 || r_hstep == 5'd5 || r_hstep == 5'd7 ||
                r_hstep == 5'd10 || r_hstep == 5'd12) begin
                if (!mul_last) begin
                    r_acc <= r_acc + pp;
                    r_pp  <= r_pp + 2'd1;
                end else begin
                    r_pp <= 2'd0;
                end
            end else begin
                r_acc <= '0;
            end
            case (r_hstep)
                5'd1: begin
                    r_a <= {r_acc[32:0], r_acc[63:33]};
                    r_b <= bfiq_pkg::MM_C2;
                end
                5'd3: begin
                    r_h1 <= r_acc ^ 64'd8;
                    r_h2 <= 64'd8;
                end
                5'd4: begin
                    r_h1 <= r_h1 + r_h2;
                    r_h2 <= r_h2 + r_h1 + r_h2;
                    r_a  <= (r_h1 + r_h2) ^ ((r_h1 + r_h2) >> 33);
                    r_b  <= bfiq_pkg::FM_C1;
                end
                5'd6: begin
                    r_a <= r_acc ^ (r_acc >> 33);
                    r_b <= bfiq_pkg::FM_C2;
                end
                5'd8: r_h1 <= r_acc ^ (r_acc >> 33);
                5'd9: begin
                    r_a <= r_h2 ^ (r_h2 >> 33);
                    r_b <= bfiq_pkg::FM_C1;
                end
                5'd11: begin
                    r_a <= r_acc ^ (r_acc >> 33);
                    r_b <= bfiq_pkg::FM_C2;
                end
                5'd13: r_h2 <= r_acc ^ (r_acc >> 33);
                5'd14: begin
                    r_h1 <= r_h1 + r_h2;
                    r_h2 <= r_h2 + r_h1 + r_h2;
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        n_hstep = r_hstep;
        if (r_hstep == 5'd0 || r_hstep == 5'd2 || r_hstep == 5'd5 || r_hstep == 5'd7 ||
            r_hstep == 5'd10 || r_hstep == 5'd12) begin
            if (mul_last) n_hstep = r_hstep + 5'd1;
        end else if (r_hstep != 5'd15) begin
            n_hstep = r_hstep + 5'd1;
        end
    end

    assign o_sts.hash_done = (r_hstep == 5'd14);

    // ---------------- probe value and modulo ----------------
    // r_cur runs through h1 + n*h2; r_step holds h2.
    logic [63:0]               r_cur, r_step;
    logic [63:0]               r_pv, r_rem;
    logic [bfiq_pkg::NH_W-1:0] r_n;
    logic [MW-1:0]             r_m;
    logic [6:0]                r_mcnt;

    logic [MW-1:0] m_sat;
    always_comb begin
        if (i_filter_size == '0) begin
            m_sat = MW'(1);
        end else if ({{(32-bfiq_pkg::FS_W){1'b0}}, i_filter_size} > 32'(FILTER_BITS)) begin
            m_sat = MW'(FILTER_BITS);
        end else begin
            m_sat = MW'(i_filter_size);
        end
    end

    // Restoring division, one quotient bit per cycle, remainder only.
    logic [MW:0]   part;
    logic [MW:0]   part_sub;
    assign part     = {r_rem[MW-1:0], r_pv[63]};
    assign part_sub = part - {1'b0, r_m};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_n <= '0;
        end else if (i_cmd.next_probe) begin
            r_n <= r_n + 1'b1;
        end
        if (i_cmd.mod_start) begin
            r_pv   <= r_cur;
            r_m    <= m_sat;
            r_rem  <= '0;
            r_mcnt <= 7'd0;
        end else if (i_cmd.mod_step && r_mcnt != 7'd64) begin
            r_mcnt <= r_mcnt + 7'd1;
            r_pv   <= {r_pv[62:0], r_pv[63]};
            if (!part_sub[MW]) r_rem <= {{(64-MW){1'b0}}, part_sub[MW-1:0]};
            else               r_rem <= {{(64-MW){1'b0}}, part[MW-1:0]};
        end
    end

    assign o_sts.mod_done = (r_mcnt == 7'd64);

    always_ff @(posedge i_clk) begin
        if (i_cmd.hash_step && r_hstep == 5'd14) begin
            r_cur  <= r_h1 + r_h2;
            r_step <= r_h2 + r_h1 + r_h2;
        end else if (i_cmd.next_probe) begin
            r_cur <= r_cur + r_step;
        end
    end

    assign o_sts.probes_done = ({1'b0, r_n} >= {1'b0, i_num_hashes});

    // ---------------- bit store ----------------
    logic            r_mem [FILTER_BITS];
    logic            r_rd;
    logic [AW:0]     r_clr;
    logic [AW-1:0]   addr;

    assign addr = i_cmd.clr_step ? r_clr[AW-1:0] : r_rem[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step) begin
            r_mem[addr] <= 1'b0;
        end else if (i_cmd.mem_access && r_op == bfiq_pkg::OP_INSERT) begin
            r_mem[addr] <= 1'b1;
        end
        r_rd <= r_mem[addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clr_step && !r_clr[AW]) begin
            r_clr <= r_clr + 1'b1;
        end
    end
    assign o_sts.clr_done = (r_clr == (AW+1)'(FILTER_BITS - 1));

    logic r_found;
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_found <= 1'b1;
        end else if (i_cmd.next_probe && r_op == bfiq_pkg::OP_QUERY && !r_rd) begin
            r_found <= 1'b0;
        end
    end
    assign o_sts.bit_zero = (r_op == bfiq_pkg::OP_QUERY) && !r_rd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_cmd.done;
        end
        o_maybe_present <= (r_op == bfiq_pkg::OP_INSERT) ? 1'b1 : r_found;
    end

endmodule

`default_nettype wire

@@ tb/bloom_filter_insert_query_tb.sv @@
// ----------------------------------------------------------------------------
// Bloom filter insert/query testbench
// Sends insert and query commands with random gaps, keeps its own copy of the
// bit store and the probe sequence, and checks every result strobe in order.
// ----------------------------------------------------------------------------
`default_nettype none

module bloom_filter_insert_query_tb;
    import bfiq_pkg::*;

    localparam int NBITS       = 1024;
    localparam int CYCLE_LIMIT = 12000000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  i_opcode = OP_INSERT;
    logic [KEY_W-1:0]      i_key = '0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  busy;
    logic                  o_valid;
    logic                  o_maybe_present;

    bloom_filter_insert_query #(.FILTER_BITS(NBITS)) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_opcode        (i_opcode),
        .i_key           (i_key),
        .o_valid         (o_valid),
        .o_maybe_present (o_maybe_present),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Model state.
    bit              store_bits [NBITS];
    bit [NH_W-1:0]   probe_count;
    bit [FS_W-1:0]   size_reg;
    bit              presence_q [$];
    bit [63:0]       inserted_keys [$];
    int              mismatch_count;
    int              cycle_count;

    function automatic bit [63:0] rotl(input bit [63:0] x, input int r);
        return (x << r) | (x >> (64 - r));
    endfunction

    function automatic bit [63:0] finalize(input bit [63:0] k);
        k ^= k >> 33;
        k *= FM_C1;
        k ^= k >> 33;
        k *= FM_C2;
        k ^= k >> 33;
        return k;
    endfunction

    // Computes the answer for one command and updates the model store.
    function automatic bit lookup_or_insert(input logic op, input bit [63:0] key);
        bit [63:0] k1, h1, h2, m, idx;
        bit        found;
        found = 1'b1;
        k1 = key * MM_C1;
        k1 = rotl(k1, 31);
        k1 = k1 * MM_C2;
        h1 = k1 ^ 64'd8;
        h2 = 64'd8;
        h1 = h1 + h2;
        h2 = h2 + h1;
        h1 = finalize(h1);
        h2 = finalize(h2);
        h1 = h1 + h2;
        h2 = h2 + h1;
        m = size_reg;
        if (m == 0) m = 1;
        if (m > NBITS) m = NBITS;
        for (int n = 0; n < probe_count; n++) begin
            idx = (h1 + 64'(n) * h2) % m;
            if (op == OP_INSERT) begin
                store_bits[idx] = 1'b1;
            end else if (!store_bits[idx]) begin
                found = 1'b0;
                break;
            end
        end
        return (op == OP_INSERT) ? 1'b1 : found;
    endfunction

    task automatic report_mismatch(input string what);
        $display("ERROR at cycle %0d: %s", cycle_count, what);
        mismatch_count++;
    endtask

    // Result checker: the receiver cannot stall, so every strobe is taken.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n && o_valid) begin
            if (presence_q.size() == 0) begin
                report_mismatch("result word with no command outstanding");
            end else begin
                bit exp_bit;
                exp_bit = presence_q.pop_front();
                if (o_maybe_present !== exp_bit)
                    report_mismatch($sformatf("maybe_present %b, expected %b",
                                              o_maybe_present, exp_bit));
            end
        end
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout");
            $display("Mismatches found");
            $finish;
        end
    end

    // Waits for all outstanding results and for the block to go idle.
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (presence_q.size() != 0 || busy) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= CFG_DATA_W'(value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == REG_NUM_HASHES) probe_count = NH_W'(value);
        else size_reg = FS_W'(value);
    endtask

    task automatic configure(input int hashes, input int size);
        drain();
        write_reg(REG_NUM_HASHES, hashes);
        write_reg(REG_FILTER_SIZE, size);
    endtask

    // Sends one command word; a zero gap keeps start high back to back.
    task automatic send_cmd(input logic op, input bit [63:0] key);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start    <= 1'b1;
        i_opcode <= op;
        i_key    <= key;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        presence_q.push_back(lookup_or_insert(op, key));
        if (op == OP_INSERT) inserted_keys.push_back(key);
    endtask

    function automatic bit [63:0] rand_key();
        return {$urandom(), $urandom()};
    endfunction

    task automatic test_defaults();
        send_cmd(OP_QUERY, 64'd0);
        send_cmd(OP_INSERT, 64'd0);
        send_cmd(OP_INSERT, '1);
        send_cmd(OP_QUERY, 64'd0);
        send_cmd(OP_QUERY, '1);
        send_cmd(OP_QUERY, 64'h8000_0000_0000_0001);
        send_cmd(OP_QUERY, 64'h5555_aaaa_5555_aaaa);
    endtask

    task automatic test_zero_probes();
        configure(0, 64);
        send_cmd(OP_QUERY, 64'h1234_5678_9abc_def0);
        send_cmd(OP_INSERT, 64'h1234_5678_9abc_def0);
        send_cmd(OP_QUERY, rand_key());
    endtask

    task automatic test_size_extremes();
        // A zero size is taken as one, so every probe lands on bit 0.
        configure(4, 0);
        send_cmd(OP_QUERY, rand_key());
        send_cmd(OP_INSERT, rand_key());
        send_cmd(OP_QUERY, rand_key());
        configure(5, 1024);
        send_cmd(OP_QUERY, rand_key());
        send_cmd(OP_INSERT, 64'hdead_beef_0000_0001);
        send_cmd(OP_QUERY, 64'hdead_beef_0000_0001);
        // Sizes above the store saturate to the store size.
        configure(5, 2047);
        send_cmd(OP_QUERY, 64'hdead_beef_0000_0001);
        send_cmd(OP_QUERY, rand_key());
        // Shrinking keeps the stored bits; probes use the new modulus.
        configure(3, 7);
        send_cmd(OP_QUERY, 64'hdead_beef_0000_0001);
    endtask

    task automatic test_max_probes();
        configure(63, 1024);
        send_cmd(OP_INSERT, 64'h0123_4567_89ab_cdef);
        send_cmd(OP_QUERY, 64'h0123_4567_89ab_cdef);
        configure(32, 2000);
        send_cmd(OP_QUERY, 64'h0123_4567_89ab_cdef);
        send_cmd(OP_QUERY, rand_key());
    endtask

    // Mix of inserts, queries of known keys and queries of fresh keys.
    task automatic test_random();
        int hashes [6] = '{3, 1, 7, 2, 12, 6};
        int sizes  [6] = '{1024, 37, 200, 8, 1024, 511};
        for (int p = 0; p < 6; p++) begin
            configure(hashes[p], sizes[p]);
            for (int i = 0; i < 122; i++) begin
                int pick;
                pick = $urandom_range(0, 9);
                if (pick < 4 || inserted_keys.size() == 0)
                    send_cmd(OP_INSERT, rand_key());
                else if (pick < 7)
                    send_cmd(OP_QUERY,
                             inserted_keys[$urandom_range(0, inserted_keys.size() - 1)]);
                else
                    send_cmd(OP_QUERY, rand_key());
            end
        end
    endtask

    initial begin
        mismatch_count = 0;
        cycle_count    = 0;
        probe_count    = NUM_HASHES_RST;
        size_reg       = FILTER_SIZE_RST;
        foreach (store_bits[i]) store_bits[i] = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // Let the clearing sweep finish before the first command.
        while (busy) @(posedge i_clk);
        test_defaults();
        test_zero_probes();
        test_size_extremes();
        test_max_probes();
        test_random();
        drain();
        repeat (100) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

`default_nettype wire
